@@ sv/oaids_pkg.sv @@
// Shared types and constants for the ordered array store.
// Used by oaids_store, oaids_ctrl and ordered_array_insert_delete_search.
package oaids_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);   // index width
	localparam int CW    = AW + 1;          // count width, holds DEPTH itself
	localparam int WW    = 32;              // word width

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef logic [WW-1:0] word_t;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_READ   = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4,
		OP_SEARCH = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// request from the sequencer to the word memory
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		word_t         wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

endpackage

@@ sv/ordered_array_insert_delete_search.sv @@
// Packed array store of signed 32-bit words with a fill count. Each input
// transaction is one operation (clear, append, read, insert, delete, search)
// and gives exactly one result transaction carrying status, search result,
// read word and the fill count after the operation. Rejected operations
// (bad index, full, empty) leave store and count unchanged. One operation is
// handled at a time: in_ready is high only while the block is idle, and the
// result waits in its register until out_ready takes it. Clear, append and
// rejected ops complete straight from idle; read waits for the registered
// word; insert at p shifts entries from the last down to p one slot up,
// then writes the new word at p; delete shifts entries above p one slot
// down; search compares from index 0 upward to a match or the last entry.
// The walks are bound by the word memory's single read port and single
// write port, one entry per cycle, with shift reads and writes overlapped.
// No clearing pass after reset: only entries below the fill count are read.
// Depends on oaids_pkg, oaids_store and oaids_ctrl.
module ordered_array_insert_delete_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      op,
	input  logic [oaids_pkg::CW-1:0]        position,
	input  logic signed [oaids_pkg::WW-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic                            found,
	output logic [oaids_pkg::AW-1:0]        found_index,
	output logic signed [oaids_pkg::WW-1:0] read_data,
	output logic [oaids_pkg::CW-1:0]        fill_count
);

	oaids_pkg::mem_req_t mem_req;
	oaids_pkg::word_t    mem_rdata;

	// sequencer: decode, checks, shift/search walks, result register
	oaids_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found       (found),
		.found_index (found_index),
		.read_data   (read_data),
		.fill_count  (fill_count),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	// word memory, contents undefined until written
	oaids_store u_store (
		.clk       (clk),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ sv/oaids_store.sv @@
// Word memory: one write port, one read port with registered read data.
// Depends on oaids_pkg.
module oaids_store (
	input  logic                clk,
	input  oaids_pkg::mem_req_t mem_req,
	output oaids_pkg::word_t    mem_rdata
);

	oaids_pkg::word_t mem_q [oaids_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
		mem_rdata <= mem_q[mem_req.raddr];
	end

endmodule

@@ sv/oaids_ctrl.sv @@
// Operation sequencer: decode, range checks, shift walk, search walk, result register.
// Depends on oaids_pkg; drives the oaids_store ports.
module oaids_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     op,
	input  logic [oaids_pkg::CW-1:0]       position,
	input  logic signed [oaids_pkg::WW-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic                           found,
	output logic [oaids_pkg::AW-1:0]       found_index,
	output logic signed [oaids_pkg::WW-1:0] read_data,
	output logic [oaids_pkg::CW-1:0]       fill_count,
	output oaids_pkg::mem_req_t            mem_req,
	input  oaids_pkg::word_t               mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_SHIFT, S_DRAIN, S_FINAL, S_SRCH, S_DONE
	} state_t;

	state_t                     state_q;
	logic [oaids_pkg::CW-1:0]   count_q;
	logic [oaids_pkg::CW-1:0]   ptr_q;
	logic [oaids_pkg::AW-1:0]   end_q;
	logic                       up_q;
	logic                       ins_q;
	logic                       pend_q;
	logic [oaids_pkg::AW-1:0]   pend_addr_q;
	logic [oaids_pkg::AW-1:0]   pos_q;
	oaids_pkg::word_t           val_q;
	logic                       chk_q;
	logic [oaids_pkg::AW-1:0]   chk_idx_q;
	logic [1:0]                 status_q;
	logic                       found_q;
	logic [oaids_pkg::AW-1:0]   fidx_q;
	oaids_pkg::word_t           rdata_q;

	logic                       accept;
	logic                       full;
	logic                       empty;
	logic [oaids_pkg::AW-1:0]   last_idx;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign full        = (count_q >= oaids_pkg::DEPTH_C);
	assign empty       = (count_q == '0);
	assign last_idx    = oaids_pkg::AW'(count_q - 1'b1);

	assign out_valid   = (state_q == S_DONE);
	assign status      = status_q;
	assign found       = found_q;
	assign found_index = fidx_q;
	assign read_data   = rdata_q;
	assign fill_count  = count_q;

	// memory port steering
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = pend_addr_q;
		mem_req.wdata = mem_rdata;
		mem_req.raddr = (state_q == S_IDLE) ? position[oaids_pkg::AW-1:0]
		                                    : ptr_q[oaids_pkg::AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept && op == oaids_pkg::OP_APPEND && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = count_q[oaids_pkg::AW-1:0];
					mem_req.wdata = value;
				end
			end
			S_SHIFT, S_DRAIN: begin
				mem_req.we = pend_q;
			end
			S_FINAL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				mem_req.wdata = val_q;
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			up_q        <= 1'b0;
			ins_q       <= 1'b0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			pos_q       <= '0;
			val_q       <= '0;
			chk_q       <= 1'b0;
			chk_idx_q   <= '0;
			status_q    <= oaids_pkg::ST_OK;
			found_q     <= 1'b0;
			fidx_q      <= '0;
			rdata_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= oaids_pkg::ST_OK;
						found_q  <= 1'b0;
						fidx_q   <= '0;
						rdata_q  <= '0;
						pos_q    <= position[oaids_pkg::AW-1:0];
						val_q    <= value;
						pend_q   <= 1'b0;
						chk_q    <= 1'b0;
						state_q  <= S_DONE;
						case (op)
							oaids_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							oaids_pkg::OP_APPEND: begin
								if (full) begin
									status_q <= oaids_pkg::ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							oaids_pkg::OP_READ: begin
								if (empty) begin
									status_q <= oaids_pkg::ST_EMPTY;
								end else if (position >= count_q) begin
									status_q <= oaids_pkg::ST_RANGE;
								end else begin
									state_q <= S_RD;
								end
							end
							oaids_pkg::OP_INSERT: begin
								if (full) begin
									status_q <= oaids_pkg::ST_FULL;
								end else if (position > count_q) begin
									status_q <= oaids_pkg::ST_RANGE;
								end else begin
									count_q <= count_q + 1'b1;
									ins_q   <= 1'b1;
									if (position == count_q) begin
										state_q <= S_FINAL;
									end else begin
										ptr_q   <= count_q - 1'b1;
										end_q   <= position[oaids_pkg::AW-1:0];
										up_q    <= 1'b0;
										state_q <= S_SHIFT;
									end
								end
							end
							oaids_pkg::OP_DELETE: begin
								if (empty) begin
									status_q <= oaids_pkg::ST_EMPTY;
								end else if (position >= count_q) begin
									status_q <= oaids_pkg::ST_RANGE;
								end else begin
									count_q <= count_q - 1'b1;
									ins_q   <= 1'b0;
									if (position[oaids_pkg::AW-1:0] != last_idx) begin
										ptr_q   <= position + 1'b1;
										end_q   <= last_idx;
										up_q    <= 1'b1;
										state_q <= S_SHIFT;
									end
								end
							end
							oaids_pkg::OP_SEARCH: begin
								if (empty) begin
									status_q <= oaids_pkg::ST_EMPTY;
								end else begin
									ptr_q   <= '0;
									state_q <= S_SRCH;
								end
							end
							default: begin
								status_q <= oaids_pkg::ST_OK;
							end
						endcase
					end
				end
				S_RD: begin
					rdata_q <= mem_rdata;
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					// read at ptr now, write it one slot over next cycle
					pend_q      <= 1'b1;
					pend_addr_q <= up_q ? oaids_pkg::AW'(ptr_q - 1'b1)
					                    : oaids_pkg::AW'(ptr_q + 1'b1);
					if (ptr_q[oaids_pkg::AW-1:0] == end_q) begin
						state_q <= S_DRAIN;
					end else if (up_q) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				S_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= ins_q ? S_FINAL : S_DONE;
				end
				S_FINAL: begin
					state_q <= S_DONE;
				end
				S_SRCH: begin
					// compare the word fetched last cycle, fetch the next one
					if (chk_q && mem_rdata == val_q) begin
						found_q <= 1'b1;
						fidx_q  <= chk_idx_q;
						chk_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (chk_q && chk_idx_q == last_idx) begin
						chk_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						chk_q     <= (ptr_q < count_q);
						chk_idx_q <= ptr_q[oaids_pkg::AW-1:0];
						if (ptr_q < count_q) begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/sv/oaids_checker.sv @@
// Scoreboard for the ordered array store: mirrors the word store and fill count,
// predicts one result per accepted operation and compares every result field.
// Depends on oaids_pkg.
module oaids_checker
	import oaids_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [2:0]             op,
	input  logic [CW-1:0]          position,
	input  logic signed [WW-1:0]   value,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [1:0]             status,
	input  logic                   found,
	input  logic [AW-1:0]          found_index,
	input  logic signed [WW-1:0]   read_data,
	input  logic [CW-1:0]          fill_count,
	output int                     mismatches,
	output int                     outstanding,
	output int                     compared,
	output logic [CW-1:0]          model_fill
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t       status;
		logic          found;
		logic [AW-1:0] found_index;
		word_t         read_data;
		logic [CW-1:0] fill_count;
	} outcome_t;

	word_t         shadow_words [DEPTH];
	logic [CW-1:0] shadow_count;
	outcome_t      awaited_results [$];

	// applies one operation to the shadow store, returns the result it should give
	function automatic outcome_t apply_array_op(logic [2:0] code, logic [CW-1:0] pos,
			word_t val);
		outcome_t r;
		r = '0;
		r.status = ST_OK;
		case (code)
			OP_CLEAR: begin
				shadow_count = '0;
			end
			OP_APPEND: begin
				if (shadow_count == DEPTH_C) begin
					r.status = ST_FULL;
				end else begin
					shadow_words[shadow_count[AW-1:0]] = val;
					shadow_count++;
				end
			end
			OP_READ: begin
				if (shadow_count == '0)
					r.status = ST_EMPTY;
				else if (pos >= shadow_count)
					r.status = ST_RANGE;
				else
					r.read_data = shadow_words[pos[AW-1:0]];
			end
			OP_INSERT: begin
				// full is checked before the position
				if (shadow_count == DEPTH_C) begin
					r.status = ST_FULL;
				end else if (pos > shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = int'(shadow_count); i > int'(pos); i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos[AW-1:0]] = val;
					shadow_count++;
				end
			end
			OP_DELETE: begin
				if (shadow_count == '0) begin
					r.status = ST_EMPTY;
				end else if (pos >= shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = int'(pos); i + 1 < int'(shadow_count); i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_count--;
				end
			end
			OP_SEARCH: begin
				if (shadow_count == '0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int i = 0; i < int'(shadow_count); i++) begin
						if (shadow_words[i] == val) begin
							r.found       = 1'b1;
							r.found_index = AW'(i);
							break;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.fill_count = shadow_count;
		return r;
	endfunction

	// inputs move at the falling edge, so both channels are stable here
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			shadow_count = '0;
			awaited_results.delete();
		end else begin
			// operation first: its result can never come back in the same cycle
			if (in_valid && in_ready)
				awaited_results.push_back(apply_array_op(op, position, value));
			if (out_valid && out_ready) begin
				got.status      = status_t'(status);
				got.found       = found;
				got.found_index = found_index;
				got.read_data   = read_data;
				got.fill_count  = fill_count;
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result with no operation outstanding: status %0d fill %0d",
							$realtime, status, fill_count);
				end else begin
					want = awaited_results.pop_front();
					compared++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("[%0t] result %0d mismatch (exp/got): status %0d/%0d ",
								$realtime, compared, want.status, got.status);
							$display("found %0d/%0d index %0d/%0d data %h/%h fill %0d/%0d",
								want.found, got.found, want.found_index, got.found_index,
								want.read_data, got.read_data, want.fill_count, got.fill_count);
						end
					end
				end
			end
		end
		outstanding = awaited_results.size();
		model_fill  = shadow_count;
	end

endmodule

@@ tb/sv/ordered_array_insert_delete_search_tb.sv @@
// Stimulus and verdict for the ordered array store: directed corner cases, then
// random operations under four handshake pressure phases.
// Depends on oaids_pkg, oaids_checker and the ordered_array_insert_delete_search RTL.
module ordered_array_insert_delete_search_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import oaids_pkg::*;

	// op codes the block decodes as no-ops
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// random walks stay short: at or above this fill, growing ops become deletes
	localparam int FILL_CAP    = 48;
	localparam int OPS_PER_PHASE = 139;
	// walks stay short with the fill capped at FILL_CAP; even with 88% stalls on
	// every transaction a run stays far below this limit
	localparam int CYCLE_LIMIT = 1_500_000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [2:0]          op;
	logic [CW-1:0]       position;
	logic signed [WW-1:0] value;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic                found;
	logic [AW-1:0]       found_index;
	logic signed [WW-1:0] read_data;
	logic [CW-1:0]       fill_count;

	int            mismatches;
	int            outstanding;
	int            compared;
	logic [CW-1:0] model_fill;

	int    ops_sent;
	int    cycle_count;
	int    idle_pct;       // chance per cycle that the sender holds off
	int    stall_pct;      // chance per cycle that the receiver stalls
	word_t value_pool [8]; // recurring words so searches hit and duplicates occur

	ordered_array_insert_delete_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found       (found),
		.found_index (found_index),
		.read_data   (read_data),
		.fill_count  (fill_count)
	);

	oaids_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found       (found),
		.found_index (found_index),
		.read_data   (read_data),
		.fill_count  (fill_count),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.model_fill  (model_fill)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver backpressure, redrawn every falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog: a hang or a lost result ends here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// One transaction on the operation channel. Called right after a falling
	// edge and returns right after one, so in_valid gets exactly one update per
	// edge: it either drops for an idle gap or carries straight into the next op.
	task automatic send_op(input logic [2:0] code, input logic [CW-1:0] pos,
			input word_t v);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		in_valid <= 1'b1;
		op       <= code;
		position <= pos;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		ops_sent++;
	endtask

	// mostly legal indexes, with the boundary, one past it, and raw 11-bit noise
	function automatic logic [CW-1:0] pick_position(int n, bit for_insert);
		int r;
		int hi;
		r  = $urandom_range(0, 99);
		hi = for_insert ? n : n - 1;
		if (r < 75 && hi >= 0)
			return CW'($urandom_range(0, hi));
		if (r < 85)
			return CW'(n);
		if (r < 93)
			return CW'(n + 1);
		return CW'($urandom_range(0, 2047));
	endfunction

	function automatic word_t pick_value();
		if ($urandom_range(0, 99) < 60)
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	task automatic random_op();
		int          n;
		int          pick;
		logic [2:0]  code;
		logic [CW-1:0] pos;
		n    = int'(model_fill);
		pick = $urandom_range(0, 99);
		if (pick < 3)
			code = OP_CLEAR;
		else if (pick < 28)
			code = OP_APPEND;
		else if (pick < 42)
			code = OP_READ;
		else if (pick < 62)
			code = OP_INSERT;
		else if (pick < 78)
			code = OP_DELETE;
		else if (pick < 96)
			code = OP_SEARCH;
		else
			code = pick[0] ? OP_SPARE_A : OP_SPARE_B;
		if (n >= FILL_CAP && (code == OP_APPEND || code == OP_INSERT))
			code = OP_DELETE;
		pos = pick_position(n, code == OP_INSERT);
		send_op(code, pos, pick_value());
	endtask

	// corner cases on an empty and a small array
	task automatic directed_ops();
		send_op(OP_READ,   '0, '0);                 // empty
		send_op(OP_DELETE, '0, '0);                 // empty
		send_op(OP_SEARCH, '0, '0);                 // empty
		send_op(OP_INSERT, CW'(1), 32'h1);          // past the end on empty
		send_op(OP_INSERT, '0, 32'h7FFF_FFFF);      // insert into empty
		send_op(OP_APPEND, '0, 32'h8000_0000);
		send_op(OP_APPEND, '0, 32'hFFFF_FFFF);
		send_op(OP_APPEND, '0, 32'h0000_0000);
		send_op(OP_INSERT, CW'(4), 32'h7FFF_FFFF);  // position == count lands at end
		send_op(OP_INSERT, CW'(2), 32'h1234_5678);  // middle, shifts three up
		send_op(OP_READ,   '0, '0);
		send_op(OP_READ,   CW'(5), '0);             // last entry
		send_op(OP_READ,   CW'(6), '0);             // == count
		send_op(OP_READ,   11'h7FF, '0);            // all index bits set
		send_op(OP_SEARCH, '0, 32'h7FFF_FFFF);      // duplicate: lowest wins
		send_op(OP_SEARCH, '0, 32'h5555_5555);      // miss
		send_op(OP_DELETE, CW'(6), '0);             // == count
		send_op(OP_DELETE, CW'(5), '0);             // last, no shift
		send_op(OP_DELETE, '0, '0);                 // first, full shift
		send_op(OP_SPARE_A, CW'(1), 32'h1);
		send_op(OP_SPARE_B, 11'h7FF, 32'hFFFF_FFFF);
		send_op(OP_INSERT, CW'(5), 32'h2);          // count + 1
		send_op(OP_CLEAR,  '0, '0);
		send_op(OP_READ,   '0, '0);                 // empty again after clear
		send_op(OP_APPEND, '0, 32'h0F0F_0F0F);
	endtask

	initial begin
		int phase;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_CLEAR;
		position  = '0;
		value     = '0;
		out_ready = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		ops_sent  = 0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom();

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phases: free running, sparse sender, heavy backpressure, light both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			if (phase == 0) begin
				directed_ops();
			end
			repeat (OPS_PER_PHASE) random_op();
		end

		// drain: one op in flight at most, so one full walk bounds the tail
		in_valid  <= 1'b0;
		stall_pct = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);

		$display("Ran %0d operations (directed and random) over four pressure phases;",
			ops_sent);
		$display("%0d results compared field by field in %0d cycles, %0d mismatches.",
			compared, cycle_count, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
